// ===== sv/b64v_pkg.sv =====
package b64v_pkg;

    localparam int DATA_W = 8;
    localparam int ERR_W  = 2;
    localparam int SYM_W  = 6;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SYM   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_COUNT = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam int REG_MODE = 0;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic [ERR_W-1:0]  err;
    } res_t;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] value;
    } sym_dec_t;

    // 6-bit value to alphabet character: 0-9, A-Z, a-z, '+', '*'
    function automatic logic [DATA_W-1:0] sym_char(input logic [SYM_W-1:0] v);
        logic [DATA_W-1:0] v8;
        logic [DATA_W-1:0] c;
        v8 = {2'b00, v};
        if (v < 6'd10) begin
            c = 8'h30 + v8;
        end else if (v < 6'd36) begin
            c = 8'h41 + v8 - 8'd10;
        end else if (v < 6'd62) begin
            c = 8'h61 + v8 - 8'd36;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2A;
        end
        return c;
    endfunction

    function automatic sym_dec_t sym_value(input logic [DATA_W-1:0] c);
        sym_dec_t r;
        logic [DATA_W-1:0] d;
        r.ok    = 1'b1;
        r.value = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r.value = d[SYM_W-1:0];
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41 + 8'd10;
            r.value = d[SYM_W-1:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd36;
            r.value = d[SYM_W-1:0];
        end else if (c == 8'h2B) begin
            r.value = 6'd62;
        end else if (c == 8'h2A) begin
            r.value = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== sv/base64_variant_stream_codec_core.sv =====
// Streaming Base64-style codec, alphabet 0-9 A-Z a-z + *, LSB-first packing,
// no padding.
// Slave stream: one byte (encode) or one symbol character (decode) per beat,
// s_tlast marks the final item of a message.
// Master stream: symbol characters (encode) or decoded bytes (decode);
// m_tuser carries the error code, m_tlast ends the message.
// APB register 0 (address 0): mode, 0 encode, 1 decode. Writing it abandons
// any unfinished message. Write only while the block is idle.
// A beat passes the input register, then the result register, to the master.
// Throughput: one input beat per cycle while each beat gives at most one
// result and the receiver does not stall. In encode, the third byte of a
// group and a final byte give two results each; the next beat then waits
// until the single result port has drained the two-entry result buffer.
// A receiver stall holds the results in the buffer; one further input beat
// is held in the input register, then s_tready drops.
// Reset (aresetn low, synchronous) empties both registers and returns mode
// to encode with phase and held bits cleared.
module base64_variant_stream_codec_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [b64v_pkg::DATA_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [b64v_pkg::DATA_W-1:0] m_tdata,   // [7:0] out_byte
    output logic [b64v_pkg::ERR_W-1:0]  m_tuser,   // [1:0] out_error
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import b64v_pkg::*;

    logic                mode_reg;
    logic [1:0]          phase_reg,  phase_next;
    logic [5:0]          held_reg,   held_next;
    logic                disc_reg,   disc_next;

    logic                in_vld_reg;
    logic [DATA_W-1:0]   in_data_reg;
    logic                in_last_reg;

    res_t                slot0_reg, slot1_reg;
    logic [1:0]          cnt_reg;

    res_t                r0, r1;
    logic [1:0]          n_res;
    logic                out_free, proc, pop, cfg_wr;
    sym_dec_t            sd;
    logic [DATA_W-1:0]   u8, h8, dbyte;
    logic [1:0]          ep;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {31'b0, mode_reg} : 32'b0;

    assign pop      = (cnt_reg != 2'd0) && m_tready;
    assign out_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign proc     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || proc;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg.data;
    assign m_tlast  = slot0_reg.last;
    assign m_tuser  = slot0_reg.err;

    assign sd = sym_value(in_data_reg);
    assign u8 = {2'b00, sd.value};
    assign h8 = {2'b00, held_reg};
    assign ep = (phase_reg == 2'd3) ? 2'd0 : phase_reg;

    always_comb begin
        r0         = '0;
        r1         = '0;
        n_res      = 2'd0;
        phase_next = phase_reg;
        held_next  = held_reg;
        disc_next  = disc_reg;
        dbyte      = '0;
        if (disc_reg) begin
            if (in_last_reg) begin
                disc_next  = 1'b0;
                phase_next = 2'd0;
                held_next  = '0;
            end
        end else if (mode_reg == MODE_ENCODE) begin
            n_res = 2'd1;
            case (ep)
                2'd0: begin
                    r0.data    = sym_char(in_data_reg[5:0]);
                    held_next  = {4'b0, in_data_reg[7:6]};
                    phase_next = 2'd1;
                    if (in_last_reg) begin
                        r1.data = sym_char({4'b0, in_data_reg[7:6]});
                        r1.last = 1'b1;
                        n_res   = 2'd2;
                    end
                end
                2'd1: begin
                    r0.data    = sym_char(held_reg | {in_data_reg[3:0], 2'b00});
                    held_next  = {2'b0, in_data_reg[7:4]};
                    phase_next = 2'd2;
                    if (in_last_reg) begin
                        r1.data = sym_char({2'b0, in_data_reg[7:4]});
                        r1.last = 1'b1;
                        n_res   = 2'd2;
                    end
                end
                default: begin
                    r0.data    = sym_char(held_reg | {in_data_reg[1:0], 4'b0000});
                    r1.data    = sym_char(in_data_reg[7:2]);
                    r1.last    = in_last_reg;
                    n_res      = 2'd2;
                    phase_next = 2'd0;
                    held_next  = '0;
                end
            endcase
            if (in_last_reg) begin
                phase_next = 2'd0;
                held_next  = '0;
            end
        end else begin
            if (in_last_reg && phase_reg == 2'd0) begin
                r0.last    = 1'b1;
                r0.err     = ERR_COUNT;
                n_res      = 2'd1;
                phase_next = 2'd0;
                held_next  = '0;
            end else if (!sd.ok) begin
                r0.last    = 1'b1;
                r0.err     = ERR_SYM;
                n_res      = 2'd1;
                phase_next = 2'd0;
                held_next  = '0;
                disc_next  = !in_last_reg;
            end else begin
                n_res = 2'd1;
                case (phase_reg)
                    2'd0: begin
                        held_next  = sd.value;
                        phase_next = 2'd1;
                        n_res      = 2'd0;
                    end
                    2'd1: begin
                        dbyte      = h8 | (u8 << 6);
                        held_next  = {2'b0, sd.value[5:2]};
                        phase_next = 2'd2;
                    end
                    2'd2: begin
                        dbyte      = h8 | (u8 << 4);
                        held_next  = {4'b0, sd.value[5:4]};
                        phase_next = 2'd3;
                    end
                    default: begin
                        dbyte      = h8 | (u8 << 2);
                        held_next  = '0;
                        phase_next = 2'd0;
                    end
                endcase
                r0.data = dbyte;
                r0.last = in_last_reg;
                if (in_last_reg) begin
                    phase_next = 2'd0;
                    held_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ENCODE;
            phase_reg  <= '0;
            held_reg   <= '0;
            disc_reg   <= 1'b0;
            in_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                mode_reg  <= pwdata[0];
                phase_reg <= '0;
                held_reg  <= '0;
                disc_reg  <= 1'b0;
            end else if (proc) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                disc_reg  <= disc_next;
            end

            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (proc) begin
                in_vld_reg <= 1'b0;
            end

            // a new beat only lands when the buffer is empty or emptying
            if (proc) begin
                cnt_reg <= n_res;
            end else if (pop) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc) begin
            slot0_reg <= r0;
            slot1_reg <= r1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import b64v_pkg::*;

    localparam int REG_SPARE   = 1;       // unmapped register index, writes are dropped
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 8;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;     // [7:0] in_byte
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;          // [7:0] out_byte
    logic [ERR_W-1:0]    m_tuser;          // [1:0] out_error
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    base64_variant_stream_codec_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // codec state as the block should hold it
    logic       cur_mode   = MODE_ENCODE;
    logic [1:0] grp_pos    = '0;
    logic [5:0] carry_bits = '0;
    logic       dropping   = 1'b0;

    res_t out_pending[$];
    int   mismatches  = 0;
    int   beats_taken = 0;
    int   send_idle   = 0;
    int   recv_stall  = 0;
    int   hold_cycles = 0;
    int   cycles      = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, out_pending.size());
            $display("base64_variant_stream_codec_core regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] glyph_of(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd10)
            return 8'h30 + w;
        if (v < 6'd36)
            return 8'h41 + (w - 8'd10);
        if (v < 6'd62)
            return 8'h61 + (w - 8'd36);
        return (v == 6'd62) ? 8'h2B : 8'h2A;
    endfunction

    // -1 for anything outside the alphabet
    function automatic int glyph_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "A" && c <= "Z") return int'(c) - 65 + 10;
        if (c >= "a" && c <= "z") return int'(c) - 97 + 36;
        if (c == "+") return 62;
        if (c == "*") return 63;
        return -1;
    endfunction

    function automatic void owe(input logic [7:0] d, input logic l, input logic [ERR_W-1:0] e);
        res_t r;
        r.data = d;
        r.last = l;
        r.err  = e;
        out_pending.push_back(r);
    endfunction

    // expected results of one accepted beat
    function automatic void codec_step(input logic [7:0] b, input logic last);
        int         v;
        logic [5:0] u;
        logic [7:0] y;
        if (dropping) begin
            if (last) begin
                dropping   = 1'b0;
                grp_pos    = '0;
                carry_bits = '0;
            end
            return;
        end
        if (cur_mode == MODE_ENCODE) begin
            case (grp_pos)
                2'd1: begin
                    owe(glyph_of({b[3:0], carry_bits[1:0]}), 1'b0, ERR_NONE);
                    carry_bits = {2'b00, b[7:4]};
                    grp_pos    = 2'd2;
                    if (last)
                        owe(glyph_of({2'b00, carry_bits[3:0]}), 1'b1, ERR_NONE);
                end
                2'd2: begin
                    owe(glyph_of({b[1:0], carry_bits[3:0]}), 1'b0, ERR_NONE);
                    owe(glyph_of(b[7:2]), last, ERR_NONE);
                    grp_pos    = '0;
                    carry_bits = '0;
                end
                default: begin
                    owe(glyph_of(b[5:0]), 1'b0, ERR_NONE);
                    carry_bits = {4'b0000, b[7:6]};
                    grp_pos    = 2'd1;
                    if (last)
                        owe(glyph_of({4'b0000, carry_bits[1:0]}), 1'b1, ERR_NONE);
                end
            endcase
            if (last) begin
                grp_pos    = '0;
                carry_bits = '0;
            end
            return;
        end
        v = glyph_value(b);
        // a lone trailing symbol wins over a bad character
        if (last && grp_pos == 2'd0) begin
            owe(8'h00, 1'b1, ERR_COUNT);
            return;
        end
        if (v < 0) begin
            owe(8'h00, 1'b1, ERR_SYM);
            grp_pos    = '0;
            carry_bits = '0;
            if (!last)
                dropping = 1'b1;
            return;
        end
        u = v[5:0];
        case (grp_pos)
            2'd0: begin
                carry_bits = u;
                grp_pos    = 2'd1;
                return;
            end
            2'd1: begin
                y          = {u[1:0], carry_bits};
                carry_bits = {2'b00, u[5:2]};
                grp_pos    = 2'd2;
            end
            2'd2: begin
                y          = {u[3:0], carry_bits[3:0]};
                carry_bits = {4'b0000, u[5:4]};
                grp_pos    = 2'd3;
            end
            default: begin
                y          = {u, carry_bits[1:0]};
                carry_bits = '0;
                grp_pos    = 2'd0;
            end
        endcase
        owe(y, last, ERR_NONE);
        if (last) begin
            grp_pos    = '0;
            carry_bits = '0;
        end
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (out_pending.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %h last %b error %0d",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                want = out_pending.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: out_last expected %b actual %b", $time, want.last, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.err) begin
                    $display("%0t: out_error expected %0d actual %0d", $time, want.err, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // receiver: long hold-off when asked, else random stalls
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall);
        end
    end

    // entered and left at a falling edge; tvalid stays high for a following beat
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        codec_step(b, last);
        beats_taken++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (out_pending.size() != 0)
            @(negedge aclk);
        // a beat with no result may still be in flight
        repeat (DRAIN_TAIL) @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input int index, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = 3'(index * 4);
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr && index == REG_MODE) begin
            cur_mode   = wdata[0];
            grp_pos    = '0;
            carry_bits = '0;
            dropping   = 1'b0;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_mode(input logic m);
        logic [31:0] rd;
        wait_idle();
        apb_access(1'b1, REG_MODE, {31'd0, m}, rd);
    endtask

    task automatic send_byte_msg();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic send_symbol_msg();
        int         kind;
        int         len;
        int         bad_at;
        logic [7:0] c;
        kind = $urandom_range(99);
        len  = $urandom_range(2, 9);
        if (kind < 10)
            len = 4 * $urandom_range(0, 2) + 1;
        else
            while (len % 4 == 1) len = $urandom_range(2, 9);
        bad_at = (kind >= 10 && kind < 25) ? $urandom_range(len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (kind >= 95) begin
                c = 8'($urandom_range(255));
            end else if (i == bad_at) begin
                do c = 8'($urandom_range(255)); while (glyph_value(c) >= 0);
            end else begin
                c = glyph_of(6'($urandom_range(63)));
            end
            send_beat(c, i == len - 1);
        end
    endtask

    task automatic test_encode_directed();
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'hA5, 1'b0);
        send_beat(8'h5A, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h3C, 1'b0);
        send_beat(8'hC3, 1'b0);
        send_beat(8'h81, 1'b0);
        send_beat(8'h7E, 1'b1);
    endtask

    task automatic test_decode_directed();
        set_mode(MODE_DECODE);
        send_beat("*", 1'b1);          // single symbol: count error
        send_beat("+", 1'b0);
        send_beat("0", 1'b1);
        send_beat("z", 1'b0);
        send_beat("Z", 1'b0);
        send_beat("*", 1'b1);
        // bad character on a lone trailing symbol still reports the count
        send_beat("0", 1'b0);
        send_beat("1", 1'b0);
        send_beat("2", 1'b0);
        send_beat("3", 1'b0);
        send_beat("@", 1'b1);
        // bad character mid-message, rest dropped up to tlast
        send_beat("0", 1'b0);
        send_beat("@", 1'b0);
        send_beat("x", 1'b0);
        send_beat("y", 1'b1);
        send_beat("A", 1'b0);
        send_beat("!", 1'b1);
    endtask

    task automatic test_mode_register();
        logic [31:0] rd;
        set_mode(MODE_DECODE);
        apb_access(1'b0, REG_MODE, 32'd0, rd);
        if (rd !== {31'd0, MODE_DECODE}) begin
            $display("%0t: mode readback expected %h actual %h", $time, {31'd0, MODE_DECODE}, rd);
            mismatches++;
        end
        apb_access(1'b1, REG_SPARE, 32'hFFFF_FFFF, rd);
        // unfinished message is dropped by the mode write
        send_beat("0", 1'b0);
        send_beat("1", 1'b0);
        set_mode(MODE_DECODE);
        send_beat("A", 1'b0);
        send_beat("B", 1'b1);
        send_beat(8'h55, 1'b0);        // dropped mid-message as well
        wait_idle();
        apb_access(1'b1, REG_MODE, 32'hFFFF_FFFE, rd);
        send_beat(8'h12, 1'b1);
    endtask

    task automatic test_random_traffic();
        int idle_pct[4];
        int stall_pct[4];
        int stop_at;
        idle_pct  = '{0, 77, 0, 6};
        stall_pct = '{0, 0, 77, 6};
        for (int ph = 0; ph < 4; ph++) begin
            for (int m = 0; m < 2; m++) begin
                set_mode(m == 0 ? MODE_ENCODE : MODE_DECODE);
                send_idle  = idle_pct[ph];
                recv_stall = stall_pct[ph];
                stop_at    = beats_taken + 160;
                while (beats_taken < stop_at) begin
                    if (m == 0)
                        send_byte_msg();
                    else
                        send_symbol_msg();
                end
            end
        end
        send_idle  = 0;
        recv_stall = 0;
    endtask

    task automatic test_backpressure();
        set_mode(MODE_ENCODE);
        hold_cycles = 300;
        for (int i = 0; i < 16; i++)
            send_beat(8'($urandom_range(255)), i == 15);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        test_encode_directed();
        test_decode_directed();
        test_mode_register();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("base64_variant_stream_codec_core regression: pass");
        else
            $display("base64_variant_stream_codec_core regression: fail");
        $finish;
    end

endmodule
